>>> hw/rtl/sat_pkg.sv
// Shared types and codes for the section address translator.
// Used by sat_match_unit, section_address_translator and the dv files; depends on nothing.
`default_nettype none

package sat_pkg;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned COUNT_W = 5;
   localparam int unsigned INDEX_W = 4;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_LOOKUP = 1'b1;

   typedef struct packed {
      logic               action;
      logic [INDEX_W-1:0] entry_index;
      logic [ADDR_W-1:0]  entry_start;
      logic [ADDR_W-1:0]  entry_length;
      logic [ADDR_W-1:0]  entry_file_pos;
      logic [ADDR_W-1:0]  rva;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0] file_offset;
      logic              found;
   } rsp_word_type;

   // One stored section as it sits in a table row.
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
      logic [ADDR_W-1:0] file_pos;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

>>> hw/rtl/sat_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module sat_ram #(
   parameter int unsigned WIDTH = 96,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/sat_match_unit.sv
// Shared range compare: decides whether an address falls inside one section.
// Depends on sat_pkg for the entry layout.
`default_nettype none

module sat_match_unit (
   input  wire logic [sat_pkg::ADDR_W-1:0] addr,
   input  wire sat_pkg::entry_type         entry,
   output logic                            hit
);
   import sat_pkg::*;

   logic [ADDR_W-1:0] range_end;

   // The end of the range wraps modulo 2^32, exactly as the section table defines it.
   assign range_end = entry.start + entry.length;
   assign hit       = (entry.start <= addr) && (range_end > addr);

endmodule

`default_nettype wire

>>> hw/rtl/section_address_translator.sv
// Section address translator: one compare a cycle on the match unit while a lookup scans.
// A write word is taken and gives no result; the next word may follow at once.
// A lookup compares the entries in table order up to the section count, clipped to the table
// size, and stops at the first hit; its result is loaded once the output register is free.
// The next word is taken the cycle after the result is loaded, so a new lookup waits for the last.
// Synchronous active-high reset clears the sequencer, count and output valid; not the table.
`default_nettype none

module section_address_translator #(
   parameter int unsigned MAX_SECTIONS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire sat_pkg::req_word_type         req_data,

   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output sat_pkg::rsp_word_type              rsp_data,

   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [sat_pkg::COUNT_W-1:0]   csr_data
);
   import sat_pkg::*;

   // Table address width, and a width that can also hold the section count itself.
   localparam int unsigned AddrW  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int unsigned LimitW = $clog2(MAX_SECTIONS + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [LimitW-1:0]     limit_ff, limit_in;
   logic [LimitW-1:0]     idx_ff, idx_in;
   logic                  issued_ff, issued_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  found_ff, found_in;
   logic [ADDR_W-1:0]     hit_start_ff, hit_start_in;
   logic [ADDR_W-1:0]     hit_pos_ff, hit_pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_ff, rsp_in;

   logic                  req_take;
   logic                  wr_en;
   logic [AddrW-1:0]      wr_addr;
   entry_type             wr_entry;
   logic                  rd_en;
   logic [ENTRY_W-1:0]    rd_data;
   entry_type             rd_entry;
   logic                  hit;
   logic                  out_free;

   // Words are only taken while the sequencer rests; a waiting result does not block this,
   // because the output register holds it apart from the sequencer.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // The count register may be written whenever the port offers it.
   assign csr_ready = 1'b1;

   // Table writes happen straight from the accepted word; a slot beyond the table is dropped.
   assign wr_en    = req_take && (req_data.action == ACTION_WRITE)
                     && (32'(req_data.entry_index) < 32'(MAX_SECTIONS));
   assign wr_addr  = AddrW'(req_data.entry_index);
   assign wr_entry = '{start:    req_data.entry_start,
                       length:   req_data.entry_length,
                       file_pos: req_data.entry_file_pos};

   // The scan issues one read a cycle while entries remain; the data comes back registered from the RAM.
   assign rd_en    = (state_ff == ST_SCAN) && (idx_ff < limit_ff);
   assign rd_entry = entry_type'(rd_data);

   sat_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SECTIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AddrW-1:0]),
      .rd_data (rd_data)
   );

   sat_match_unit u_match (
      .addr  (addr_ff),
      .entry (rd_entry),
      .hit   (hit)
   );

   // The output register is free once empty or once its word is being taken this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      idx_in       = idx_ff;
      issued_in    = 1'b0;
      addr_in      = addr_ff;
      found_in     = found_ff;
      hit_start_in = hit_start_ff;
      hit_pos_in   = hit_pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_data.action == ACTION_LOOKUP)) begin
               // A count larger than the table is clipped to the table size.
               if (32'(count_ff) > 32'(MAX_SECTIONS)) begin
                  limit_in = LimitW'(MAX_SECTIONS);
               end else begin
                  limit_in = LimitW'(count_ff);
               end
               idx_in   = '0;
               addr_in  = req_data.rva;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               idx_in    = idx_ff + LimitW'(1);
               issued_in = 1'b1;
            end
            // The first matching entry wins, so the scan stops at once on a hit.
            if (issued_ff && hit) begin
               found_in     = 1'b1;
               hit_start_in = rd_entry.start;
               hit_pos_in   = rd_entry.file_pos;
               issued_in    = 1'b0;
               state_in     = ST_FINISH;
            end else if (!issued_ff && !rd_en) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.found = found_ff;
               if (found_ff) begin
                  rsp_in.file_offset = addr_ff - hit_start_ff + hit_pos_ff;
               end else begin
                  rsp_in.file_offset = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff     <= limit_in;
      idx_ff       <= idx_in;
      addr_ff      <= addr_in;
      found_ff     <= found_in;
      hit_start_ff <= hit_start_in;
      hit_pos_ff   <= hit_pos_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A new result only ever appears as the sequencer leaves its final state.
   a_rsp_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result appeared outside the finish step");

   // An accepted lookup always starts a scan on the next cycle.
   a_lookup_starts_scan : assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_data.action == ACTION_LOOKUP)) |=> (state_ff == ST_SCAN))
      else $error("lookup accepted without starting a scan");

   // The scan index never runs past the number of entries to search.
   a_idx_bounded : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= limit_ff))
      else $error("scan index beyond section limit");

   // A miss always reports a zero offset.
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.file_offset == '0))
      else $error("miss reported with a non-zero offset");

endmodule

`default_nettype wire

>>> dv/sat_translation_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the section address translator: watches all three channels and checks results.
// Depends on sat_pkg; instantiated beside the block by section_address_translator_tb.

module sat_translation_scoreboard #(
   parameter int unsigned MAX_SECTIONS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire sat_pkg::req_word_type         req_data,

   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire sat_pkg::rsp_word_type         rsp_data,

   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [sat_pkg::COUNT_W-1:0]   csr_data,

   output int                                 mismatch_count,
   output int                                 translations_due
);
   import sat_pkg::*;

   logic [ADDR_W-1:0]  sec_start    [MAX_SECTIONS];
   logic [ADDR_W-1:0]  sec_length   [MAX_SECTIONS];
   logic [ADDR_W-1:0]  sec_file_pos [MAX_SECTIONS];
   logic [COUNT_W-1:0] search_count;
   rsp_word_type       due_offsets [$];

   // The first entry in table order whose range holds the address gives the offset.
   function automatic rsp_word_type translate_rva(input logic [ADDR_W-1:0] rva);
      rsp_word_type      r;
      int unsigned       limit;
      logic [ADDR_W-1:0] hi;
      r = '0;
      limit = (search_count > MAX_SECTIONS) ? MAX_SECTIONS : search_count;
      for (int k = 0; k < limit; k++) begin
         hi = sec_start[k] + sec_length[k];
         if (!r.found && sec_start[k] <= rva && hi > rva) begin
            r.file_offset = rva - sec_start[k] + sec_file_pos[k];
            r.found       = 1'b1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         search_count = '0;
         due_offsets.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_offsets.size() == 0) begin
               $display("%0t: result word with no lookup outstanding, got offset %h found %b",
                        $time, rsp_data.file_offset, rsp_data.found);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = due_offsets.pop_front();
               if (rsp_data.found !== want.found) begin
                  $display("%0t: found expected %b, got %b", $time, want.found, rsp_data.found);
                  mismatch_count <= mismatch_count + 1;
               end
               if (rsp_data.file_offset !== want.file_offset) begin
                  $display("%0t: file_offset expected %h, got %h",
                           $time, want.file_offset, rsp_data.file_offset);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.action == ACTION_WRITE) begin
               if (req_data.entry_index < MAX_SECTIONS) begin
                  sec_start[req_data.entry_index]    = req_data.entry_start;
                  sec_length[req_data.entry_index]   = req_data.entry_length;
                  sec_file_pos[req_data.entry_index] = req_data.entry_file_pos;
               end
            end else begin
               due_offsets.push_back(translate_rva(req_data.rva));
            end
         end
         if (csr_valid && csr_ready)
            search_count = csr_data;
      end
      translations_due <= due_offsets.size();
   end

endmodule

>>> dv/section_address_translator_tb.sv
`timescale 1ns / 100ps
// Testbench top for the section address translator: clock, reset, stimulus and the verdict.
// Depends on sat_pkg, section_address_translator and sat_translation_scoreboard.

module section_address_translator_tb;
   import sat_pkg::*;

   localparam int unsigned TABLE_DEPTH   = 16;
   localparam int unsigned PHASES        = 8;
   localparam int unsigned PHASE_WORDS   = 175;
   localparam int unsigned QUIET_PHASE   = 3;
   // A lookup compares at most the whole table before its result; leave a margin on top.
   localparam int unsigned SETTLE_CYCLES = TABLE_DEPTH + 3 + 8;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned IDLE_PERCENT  = 18;

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_word_type       req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_word_type       rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data  = '0;

   int                 mismatch_count;
   int                 translations_due;
   int unsigned        cycles = 0;

   // While quiet is set neither side idles, so back-to-back words are exercised.
   bit                 quiet = 1'b0;

   // A note of what has been written, so that lookups can be aimed into stored ranges.
   // It shapes the stimulus only; the scoreboard keeps its own table for checking.
   logic [ADDR_W-1:0]  aimed_start  [TABLE_DEPTH];
   logic [ADDR_W-1:0]  aimed_length [TABLE_DEPTH];
   int unsigned        aimed_limit = 0;

   section_address_translator #(
      .MAX_SECTIONS (TABLE_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   sat_translation_scoreboard #(
      .MAX_SECTIONS (TABLE_DEPTH)
   ) translation_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .translations_due (translations_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The result side stalls at random, one decision per cycle, on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // A hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offers one word on the request channel. It is entered at a falling edge and returns at
   // the falling edge after the word has been taken, so the next word or an idle cycle can be
   // set up without a second assignment to valid in the same time step.
   task automatic drive_word(input req_word_type w);
      while (!quiet && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_section(input logic [INDEX_W-1:0] slot, input logic [ADDR_W-1:0] start,
                               input logic [ADDR_W-1:0] length, input logic [ADDR_W-1:0] pos);
      req_word_type w;
      w.action         = ACTION_WRITE;
      w.entry_index    = slot;
      w.entry_start    = start;
      w.entry_length   = length;
      w.entry_file_pos = pos;
      // The address field means nothing to a write, so it carries noise.
      w.rva            = $urandom;
      aimed_start[slot]  = start;
      aimed_length[slot] = length;
      drive_word(w);
   endtask

   task automatic send_lookup(input logic [ADDR_W-1:0] rva);
      req_word_type w;
      w.action         = ACTION_LOOKUP;
      // Entry fields are ignored by a lookup and are filled with noise.
      w.entry_index    = INDEX_W'($urandom);
      w.entry_start    = $urandom;
      w.entry_length   = $urandom;
      w.entry_file_pos = $urandom;
      w.rva            = rva;
      drive_word(w);
   endtask

   // The count may only change while the block is idle: every result has come back and the
   // block has had time to finish any word that gives no result. The last word offered has
   // already been taken, so valid drops first to keep it from being taken again.
   task automatic set_section_count(input logic [COUNT_W-1:0] value);
      req_valid <= 1'b0;
      while (translations_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      aimed_limit = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
   endtask

   // A mix of section shapes: small clustered ranges that overlap, so the first-match order
   // matters, empty ranges, ranges that run past the top of the address space, huge ranges
   // and fully random ones.
   function automatic entry_type random_section();
      entry_type e;
      e.file_pos = $urandom;
      case ($urandom_range(0, 5))
         0: begin
            e.start  = $urandom;
            e.length = $urandom;
         end
         1: begin
            e.start  = $urandom;
            e.length = '0;
         end
         2: begin
            e.start  = 32'hFFFF_FFFF - $urandom_range(0, 32'h0000_FFFF);
            e.length = $urandom_range(1, 32'h0002_0000);
         end
         3: begin
            e.start  = $urandom_range(0, 32'h0000_00FF);
            e.length = 32'hFFFF_FFFF - $urandom_range(0, 32'h0000_00FF);
         end
         default: begin
            e.start  = $urandom_range(0, 32'h0003_FFFF);
            e.length = $urandom_range(1, 32'h0002_0000);
         end
      endcase
      return e;
   endfunction

   // Most lookups land inside or on the edge of a searched section; the rest are anywhere.
   function automatic logic [ADDR_W-1:0] random_rva();
      int unsigned       roll;
      int unsigned       k;
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] l;
      roll = $urandom_range(0, 99);
      if (aimed_limit == 0 || roll < 25)
         return $urandom;
      k = $urandom_range(0, aimed_limit - 1);
      s = aimed_start[k];
      l = aimed_length[k];
      if (roll < 70)
         return (l == 0) ? s : s + ($urandom % l);
      case ($urandom_range(0, 3))
         0:       return s;
         1:       return s - 1;
         2:       return s + l;
         default: return s + l - 1;
      endcase
   endfunction

   // Each phase runs with its own section count; the extremes and counts past the table
   // size (which search the whole table) are among them.
   function automatic logic [COUNT_W-1:0] count_for_phase(input int unsigned phase);
      case (phase)
         0:       return 5'd31;
         1:       return 5'd5;
         2:       return 5'd0;
         3:       return 5'd16;
         4:       return 5'd17;
         5:       return 5'd1;
         6:       return 5'd12;
         default: return COUNT_W'($urandom_range(2, 31));
      endcase
   endfunction

   initial begin
      entry_type e;
      logic [INDEX_W-1:0] slot;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Straight after reset the count is zero, so a lookup searches nothing and misses.
      send_lookup(32'h0000_1000);

      // Fill the whole table before any lookup can search it, so that no unwritten entry is
      // ever read. The first eight entries cover the edge cases of the match rule.
      send_section(4'd0, 32'h0000_1000, 32'h0000_2000, 32'h0000_0400);
      send_section(4'd1, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF); // empty range
      send_section(4'd2, 32'h0000_0000, 32'h0000_0010, 32'h8000_0000); // starts at zero
      send_section(4'd3, 32'hFFFF_FF00, 32'h0000_0200, 32'h1234_5678); // end wraps round
      send_section(4'd4, 32'hFFFF_FF00, 32'h0000_0100, 32'h0000_0000); // end lands on zero
      send_section(4'd5, 32'hFFFF_FF00, 32'h0000_00FF, 32'hFFFF_FFF0); // offset wraps
      send_section(4'd6, 32'h0000_1800, 32'h0000_1000, 32'h0000_9000); // shadowed by slot 0
      send_section(4'd7, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000); // nearly everything
      for (int k = 8; k < TABLE_DEPTH; k++) begin
         slot = INDEX_W'(k);
         send_section(slot, 32'hA000_0000 | (k << 12), 32'h0000_0800,
                      ~(32'hA000_0000 | (k << 12)));
      end

      set_section_count(5'd16);
      send_lookup(32'h0000_0000);
      send_lookup(32'h0000_1000);
      send_lookup(32'h0000_2FFF);
      send_lookup(32'h0000_3000);
      send_lookup(32'hFFFF_FFFE);
      send_lookup(32'hFFFF_FFFF);

      // With one section searched, only slot 0 can match.
      set_section_count(5'd1);
      send_lookup(32'h0000_1000);
      send_lookup(32'h0000_0000);

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         set_section_count(count_for_phase(phase));
         quiet = (phase == QUIET_PHASE);
         for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 99) < 35) begin
               e    = random_section();
               slot = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
               send_section(slot, e.start, e.length, e.file_pos);
            end else begin
               send_lookup(random_rva());
            end
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // Drain: every lookup must have been answered before the verdict.
      while (translations_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
